/* rtl/core/sil_pkg.sv */
// sorted id list union: shared types, codes and default sizes
// used by sil_cmp and the top level under rtl/core; depends on nothing
package sil_pkg;

   localparam int DEF_LISTS      = 8;
   localparam int DEF_LIST_DEPTH = 256;

   localparam int ID_W       = 64;
   localparam int OP_W       = 2;
   localparam int IX_W       = 3;
   localparam int REQ_USER_W = OP_W + IX_W;
   localparam int RSP_USER_W = 2;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;
   localparam logic [OP_W-1:0] OP_SKIP   = 2'd3;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_LT   = 2'd1;
   localparam logic [1:0] MODE_LE   = 2'd2;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

/* rtl/core/sil_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module sil_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sil_cmp.sv */
// shared 64-bit magnitude comparator used by the sequencer
// depends on sil_pkg
module sil_cmp import sil_pkg::*; (
   input  logic [ID_W-1:0] a,
   input  logic [ID_W-1:0] b,
   output cmp_res_type     res
);

   assign res.lt = (a < b);
   assign res.eq = (a == b);

endmodule

/* rtl/core/sorted_id_list_union_unit.sv */
// sorted id list union top level: sequencer, list pointers, result register
// depends on sil_pkg, sil_ram, sil_cmp
//
// channel  dir  tdata            tuser
// req      in   doc_id[63:0]     operation[1:0], list_index[4:2]
// rsp      out  result_id[63:0]  exhausted[0], append_rejected[1]
//
// one transaction at a time; req_tready is high only while idle
// next and skip walk the lists through the single store read port and the one comparator;
// the first next/skip adds a scan of all lists
// reset clears lengths, heads and ids; the store needs no clearing
// a stalled rsp holds the finished result and the sequencer waits before idle
module sorted_id_list_union_unit import sil_pkg::*; #(
   parameter int LISTS      = DEF_LISTS,
   parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ID_W-1:0]       req_tdata,  // doc_id
   input  logic [REQ_USER_W-1:0] req_tuser,  // operation, list_index
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [ID_W-1:0]       rsp_tdata,  // result_id
   output logic [RSP_USER_W-1:0] rsp_tuser   // exhausted, append_rejected
);

   localparam int LW        = $clog2(LISTS);
   localparam int PW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int LENW      = $clog2(LIST_DEPTH + 1);
   localparam int AW        = LW + PW;
   localparam int RAM_DEPTH = LISTS * (2 ** PW);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_EXEC  = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_DEC   = 4'd3;
   localparam logic [3:0] S_DEC2  = 4'd4;
   localparam logic [3:0] S_PST   = 4'd5;
   localparam logic [3:0] S_PCHK  = 4'd6;
   localparam logic [3:0] S_PMIN  = 4'd7;
   localparam logic [3:0] S_PNXT  = 4'd8;
   localparam logic [3:0] S_AFTER = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   logic [3:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [LW-1:0]   l_ff, l_in;
   logic            range_ff, range_in;
   logic [1:0]      mode_ff, mode_in;
   logic [ID_W-1:0] best_ff, best_in;
   logic [ID_W-1:0] cur_ff, cur_in;
   logic [ID_W-1:0] up_ff, up_in;
   logic            iter_ff, iter_in;
   logic            rej_ff, rej_in;
   logic [LENW-1:0] len_ff [LISTS];
   logic [LENW-1:0] len_in [LISTS];
   logic [LENW-1:0] head_ff [LISTS];
   logic [LENW-1:0] head_in [LISTS];
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic            rsp_exh_ff, rsp_exh_in;
   logic            rsp_rej_ff, rsp_rej_in;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [ID_W-1:0] ram_rdata;
   logic [ID_W-1:0] cmp_a, cmp_b;
   cmp_res_type     cmp_res;

   logic [LW+IX_W-1:0] idx_ext;
   logic               idx_ok;
   logic [LENW-1:0]    lenl, headl;
   logic               none_left;
   logic               adv;

   sil_ram #(.WIDTH(ID_W), .DEPTH(RAM_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (id_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sil_cmp u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign idx_ext = {{LW{1'b0}}, req_tuser[REQ_USER_W-1:OP_W]};
   assign idx_ok  = (idx_ext < (LW + IX_W)'(LISTS));
   assign lenl    = len_ff[l_ff];
   assign headl   = head_ff[l_ff];

   always_comb begin
      none_left = 1'b1;
      for (int i = 0; i < LISTS; i++) begin
         if (head_ff[i] < len_ff[i]) begin
            none_left = 1'b0;
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = {rsp_rej_ff, rsp_exh_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      l_in         = l_ff;
      range_in     = range_ff;
      mode_in      = mode_ff;
      best_in      = best_ff;
      cur_in       = cur_ff;
      up_in        = up_ff;
      iter_in      = iter_ff;
      rej_in       = rej_ff;
      len_in       = len_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_exh_in   = rsp_exh_ff;
      rsp_rej_in   = rsp_rej_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = {l_ff, PW'(lenl)};
      ram_raddr    = {l_ff, PW'(headl)};
      cmp_a        = ram_rdata;
      cmp_b        = id_ff;
      adv          = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser[OP_W-1:0];
               l_in     = LW'(idx_ext);
               range_in = idx_ok;
               id_in    = req_tdata;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rej_in = 1'b0;
            case (op_ff)
               OP_CLEAR: begin
                  for (int i = 0; i < LISTS; i++) begin
                     len_in[i]  = '0;
                     head_in[i] = '0;
                  end
                  cur_in   = '0;
                  up_in    = '0;
                  iter_in  = 1'b0;
                  state_in = S_DONE;
               end
               OP_APPEND: begin
                  if (iter_ff || !range_ff || (id_ff == '0)
                      || (lenl == LENW'(LIST_DEPTH))) begin
                     rej_in   = 1'b1;
                     state_in = S_DONE;
                  end else if (lenl == '0) begin
                     ram_we       = 1'b1;
                     len_in[l_ff] = lenl + LENW'(1);
                     state_in     = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = {l_ff, PW'(lenl - LENW'(1))};
                     state_in  = S_ACHK;
                  end
               end
               default: begin
                  if (!iter_ff) begin
                     iter_in  = 1'b1;
                     l_in     = '0;
                     best_in  = '0;
                     mode_in  = MODE_NONE;
                     state_in = S_PST;
                  end else begin
                     state_in = S_DEC;
                  end
               end
            endcase
         end
         S_ACHK: begin
            if (!cmp_res.lt) begin
               rej_in = 1'b1;
            end else begin
               ram_we       = 1'b1;
               len_in[l_ff] = lenl + LENW'(1);
            end
            state_in = S_DONE;
         end
         S_DEC: begin
            cmp_a = cur_ff;
            if (op_ff == OP_NEXT) begin
               if (up_ff != '0) begin
                  cur_in   = up_ff;
                  l_in     = '0;
                  best_in  = '0;
                  mode_in  = MODE_LE;
                  state_in = S_PST;
               end else begin
                  cur_in   = '0;
                  state_in = S_DONE;
               end
            end else if (!cmp_res.lt) begin
               state_in = S_DONE;
            end else if (up_ff == '0) begin
               cur_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_DEC2;
            end
         end
         S_DEC2: begin
            cmp_a   = up_ff;
            l_in    = '0;
            best_in = '0;
            if (cmp_res.lt) begin
               mode_in = MODE_LT;
            end else begin
               cur_in  = up_ff;
               mode_in = MODE_LE;
            end
            state_in = S_PST;
         end
         S_PST: begin
            if (headl < lenl) begin
               ram_re   = 1'b1;
               state_in = S_PCHK;
            end else begin
               state_in = S_PNXT;
            end
         end
         S_PCHK: begin
            cmp_b = (mode_ff == MODE_LT) ? id_ff : cur_ff;
            adv   = ((mode_ff == MODE_LT) && cmp_res.lt)
                    || ((mode_ff == MODE_LE) && (cmp_res.lt || cmp_res.eq));
            if (adv) begin
               head_in[l_ff] = headl + LENW'(1);
               state_in      = S_PST;
            end else begin
               state_in = S_PMIN;
            end
         end
         S_PMIN: begin
            cmp_b = best_ff;
            if ((best_ff == '0) || cmp_res.lt) begin
               best_in = ram_rdata;
            end
            state_in = S_PNXT;
         end
         S_PNXT: begin
            if (l_ff == LW'(LISTS - 1)) begin
               state_in = S_AFTER;
            end else begin
               l_in     = l_ff + LW'(1);
               state_in = S_PST;
            end
         end
         S_AFTER: begin
            case (mode_ff)
               MODE_NONE: begin
                  up_in    = best_ff;
                  state_in = S_DEC;
               end
               MODE_LT: begin
                  up_in = best_ff;
                  if (best_ff == '0) begin
                     cur_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     cur_in   = best_ff;
                     l_in     = '0;
                     best_in  = '0;
                     mode_in  = MODE_LE;
                     state_in = S_PST;
                  end
               end
               default: begin
                  up_in    = best_ff;
                  state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = cur_ff;
               rsp_exh_in   = (cur_ff == '0) && none_left;
               rsp_rej_in   = rej_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         up_ff        <= '0;
         iter_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LISTS; i++) begin
            len_ff[i]  <= '0;
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         up_ff        <= up_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      l_ff       <= l_in;
      range_ff   <= range_in;
      mode_ff    <= mode_in;
      best_ff    <= best_in;
      rej_ff     <= rej_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_exh_ff <= rsp_exh_in;
      rsp_rej_ff <= rsp_rej_in;
   end

endmodule
